// ===== hw/rtl/turmite_step_engine_assert.svh =====
// ============================================================================
// Assertion macros for the turmite step engine
// Concurrent checks are written through these macros so that a build can
// leave them all out by defining NO_ASSERTIONS.
// ============================================================================
`ifndef TURMITE_STEP_ENGINE_ASSERT_SVH
`define TURMITE_STEP_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// A property that is checked at every rising edge outside of reset.
`define TSE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("turmite step engine: assertion failed");
// An antecedent that must be followed by the consequent in the next cycle.
`define TSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("turmite step engine: next-cycle assertion failed");
`else
`define TSE_ASSERT(lbl, clk, rstn, prop)
`define TSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/tse_pkg.sv =====
// ============================================================================
// tse_pkg
// Types, constants and helper functions shared by the turmite step engine.
// ============================================================================
package tse_pkg;

    // Tape and rule table dimensions.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_STATES = 16;
    localparam int MAX_COLORS = 16;

    localparam int X_IW       = $clog2(MAX_WIDTH);
    localparam int Y_IW       = $clog2(MAX_HEIGHT);
    localparam int TAPE_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int TAPE_AW    = X_IW + Y_IW;
    localparam int STATE_IW   = $clog2(MAX_STATES);
    localparam int COLOR_IW   = $clog2(MAX_COLORS);
    localparam int RULE_CELLS = MAX_STATES * MAX_COLORS;
    localparam int RULE_AW    = STATE_IW + COLOR_IW;

    // Field widths of the command and result words.
    localparam int COORD_W  = 8;
    localparam int DIM_W    = 9;
    localparam int CNT_W    = 5;
    localparam int COLOR_W  = 4;
    localparam int STATE_W  = 4;
    localparam int TURN_W   = 4;
    localparam int HEAD_W   = 2;
    localparam int CFG_IX_W = 2;

    // Largest grid size that a coordinate of COORD_W bits can reach.
    localparam logic [DIM_W-1:0] WIDTH_LIMIT  =
        DIM_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT =
        DIM_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_PLACE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_GRID_W     = 2'd0,
        CFG_GRID_H     = 2'd1,
        CFG_NUM_STATES = 2'd2,
        CFG_NUM_COLORS = 2'd3
    } t_cfg_reg;

    typedef enum logic [TURN_W-1:0] {
        TURN_FWD   = 4'd0,
        TURN_LEFT  = 4'd1,
        TURN_RIGHT = 4'd2,
        TURN_BACK  = 4'd3,
        TURN_NORTH = 4'd4,
        TURN_EAST  = 4'd5,
        TURN_SOUTH = 4'd6,
        TURN_WEST  = 4'd7,
        TURN_HOLD  = 4'd8
    } t_turn;

    typedef enum logic [HEAD_W-1:0] {
        HEAD_NORTH = 2'd0,
        HEAD_EAST  = 2'd1,
        HEAD_SOUTH = 2'd2,
        HEAD_WEST  = 2'd3
    } t_heading;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_LOOK  = 2'd2,
        S_EXEC  = 2'd3
    } t_fsm;

    typedef struct packed {
        logic               halt;
        logic [STATE_W-1:0] nstate;
        logic [TURN_W-1:0]  turn;
        logic [COLOR_W-1:0] wcol;
    } t_rule;

    typedef struct packed {
        logic [1:0]         command;
        logic [STATE_W-1:0] rule_state;
        logic [COLOR_W-1:0] rule_color;
        logic [COLOR_W-1:0] entry_write_color;
        logic [TURN_W-1:0]  entry_turn;
        logic [STATE_W-1:0] entry_next_state;
        logic               entry_halt;
        logic [COORD_W-1:0] place_x;
        logic [COORD_W-1:0] place_y;
        logic [HEAD_W-1:0]  place_heading;
        logic [STATE_W-1:0] place_state;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] ant_x_out;
        logic [COORD_W-1:0] ant_y_out;
        logic [HEAD_W-1:0]  heading_out;
        logic [STATE_W-1:0] state_out;
        logic [COLOR_W-1:0] cell_color_read;
        logic [COLOR_W-1:0] cell_color_written;
        logic               halted_out;
        logic               executed;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic look;
        logic exec;
    } t_ctrl;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic is_step;
    } t_status;

    // A size register of zero or above the limit is saturated into range.
    function automatic logic [DIM_W-1:0] dim_in_use(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        if (r == '0) begin
            res = DIM_W'(1);
        end else if (r > lim) begin
            res = lim;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] step_up(input logic [COORD_W-1:0] v,
                                                  input logic [DIM_W-1:0]   size);
        logic [DIM_W-1:0] inc;
        inc = {1'b0, v} + DIM_W'(1);
        return (inc >= size) ? '0 : inc[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] step_down(input logic [COORD_W-1:0] v,
                                                    input logic [DIM_W-1:0]   size);
        logic [DIM_W-1:0] dec;
        dec = size - DIM_W'(1);
        return (v == '0) ? dec[COORD_W-1:0] : v - COORD_W'(1);
    endfunction

    function automatic logic [HEAD_W-1:0] turn_heading(input logic [HEAD_W-1:0] h,
                                                      input logic [TURN_W-1:0] turn);
        logic [HEAD_W-1:0] res;
        case (turn)
            TURN_LEFT:  res = h + HEAD_W'(3);
            TURN_RIGHT: res = h + HEAD_W'(1);
            TURN_BACK:  res = h + HEAD_W'(2);
            TURN_NORTH: res = HEAD_NORTH;
            TURN_EAST:  res = HEAD_EAST;
            TURN_SOUTH: res = HEAD_SOUTH;
            TURN_WEST:  res = HEAD_WEST;
            default:    res = h;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/turmite_step_engine.sv =====
// ============================================================================
// turmite_step_engine
// One turmite walking a toroidal colour tape, with rule loading, ant
// placement and tape reads.
// ============================================================================
//
//  channel   handshake                     word
//  --------  ----------------------------  -------------------------------
//  command   start / busy                  i_item   (tse_pkg::t_in_item)
//  result    o_result_valid, one cycle     o_result (tse_pkg::t_out_item)
//  config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  A step passes through the accept, lookup and execute states before the
//  next accept: the tape read, the rule table read and the write-back fall
//  in them in that order. Load, place and read commands end after lookup.
//  After reset the tape and rule table are cleared one entry a cycle, so busy
//  stays high until clearing ends; configuration writes are taken throughout.
//  Each result word is shown for exactly one cycle and cannot be stalled.

module turmite_step_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tse_pkg::t_in_item             i_item,
    output tse_pkg::t_out_item            o_result,
    output logic                          o_result_valid,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tse_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [tse_pkg::DIM_W-1:0]     i_cfg_data
);
    import tse_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    // Size registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    tse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    tse_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

// ===== hw/rtl/tse_ctrl.sv =====
// ============================================================================
// tse_ctrl
// Sequencer of the engine: tape clearing after reset, command accept, the
// lookup cycle and the execute cycle of a step.
// ============================================================================
`include "turmite_step_engine_assert.svh"

module tse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tse_pkg::t_status i_status,
    output tse_pkg::t_ctrl   o_ctrl,
    output logic             o_busy
);
    import tse_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_ctrl.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctrl.accept = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_ctrl.look = 1'b1;
                // Only a step needs the rule entry; other commands finish here.
                n_state = i_status.is_step ? S_EXEC : S_IDLE;
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `TSE_ASSERT(a_ctrl_onehot, i_clk, i_rst_n, $onehot0(o_ctrl))
    `TSE_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, o_ctrl.accept, o_ctrl.look)
    `TSE_ASSERT_NEXT(a_short_cmd_done, i_clk, i_rst_n, o_ctrl.look && !i_status.is_step, !o_busy)
    `TSE_ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, o_ctrl.exec, !o_busy)

endmodule

// ===== hw/rtl/tse_datapath.sv =====
// ============================================================================
// tse_datapath
// Tape and rule memories, ant registers, size registers and the result
// word register of the turmite step engine.
// ============================================================================
`include "turmite_step_engine_assert.svh"

module tse_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tse_pkg::t_ctrl                    i_ctrl,
    input  tse_pkg::t_in_item                 i_item,
    input  logic                              i_cfg_valid,
    input  logic [tse_pkg::CFG_IX_W-1:0]      i_cfg_index,
    input  logic [tse_pkg::DIM_W-1:0]         i_cfg_data,
    output tse_pkg::t_status                  o_status,
    output tse_pkg::t_out_item                o_result,
    output logic                              o_result_valid
);
    import tse_pkg::*;

    // Memories.
    logic [COLOR_W-1:0] r_tape [TAPE_CELLS];
    t_rule              r_rules [RULE_CELLS];
    logic [COLOR_W-1:0] r_tape_rd;
    t_rule              r_rule_rd;

    // Control and ant state.
    logic [TAPE_AW-1:0] r_clr_addr;
    logic [1:0]         r_cmd;
    logic               r_in_range;
    logic [COORD_W-1:0] r_ant_x, n_ant_x;
    logic [COORD_W-1:0] r_ant_y, n_ant_y;
    logic [HEAD_W-1:0]  r_heading, n_heading;
    logic [STATE_W-1:0] r_ant_state, n_ant_state;
    logic               r_halted, n_halted;
    logic [DIM_W-1:0]   r_grid_w, r_grid_h;
    logic [CNT_W-1:0]   r_num_states, r_num_colors;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [TAPE_AW-1:0] ant_addr;
    logic [TAPE_AW-1:0] tape_raddr;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [COLOR_W-1:0] tape_wdata;
    logic               tape_we;
    logic [RULE_AW-1:0] rule_raddr;
    logic [RULE_AW-1:0] rule_waddr;
    t_rule              rule_wdata;
    logic               rule_we;
    logic               load_ok;
    logic               in_range;
    t_rule              entry;
    logic [HEAD_W-1:0]  turned;
    logic [DIM_W-1:0]   width_used;
    logic [DIM_W-1:0]   height_used;
    logic               do_step;
    logic               place_now;
    t_out_item          result;

    assign ant_addr = {r_ant_y[Y_IW-1:0], r_ant_x[X_IW-1:0]};

    // Place and read address the cell given in the command word; step and load
    // look under the head.
    assign tape_raddr = (i_item.command == CMD_PLACE || i_item.command == CMD_READ)
                      ? {i_item.place_y[Y_IW-1:0], i_item.place_x[X_IW-1:0]}
                      : ant_addr;

    assign do_step    = i_ctrl.exec && !r_halted;
    assign place_now  = i_ctrl.accept && (i_item.command == CMD_PLACE);
    assign tape_we    = i_ctrl.clear || do_step;
    assign tape_waddr = i_ctrl.clear ? r_clr_addr : ant_addr;
    assign tape_wdata = i_ctrl.clear ? '0 : entry.wcol;

    assign load_ok = (int'(i_item.rule_state) < MAX_STATES)
                  && (int'(i_item.rule_color) < MAX_COLORS);
    assign rule_we    = i_ctrl.clear
                     || (i_ctrl.accept && i_item.command == CMD_LOAD && load_ok);
    assign rule_waddr = i_ctrl.clear ? r_clr_addr[RULE_AW-1:0]
                      : {i_item.rule_state[STATE_IW-1:0], i_item.rule_color[COLOR_IW-1:0]};
    always_comb begin
        rule_wdata            = '0;
        if (!i_ctrl.clear) begin
            rule_wdata.halt       = i_item.entry_halt;
            rule_wdata.nstate     = i_item.entry_next_state;
            rule_wdata.turn       = i_item.entry_turn;
            rule_wdata.wcol       = i_item.entry_write_color;
        end
    end

    assign rule_raddr = {r_ant_state[STATE_IW-1:0], r_tape_rd[COLOR_IW-1:0]};
    assign in_range   = ({1'b0, r_ant_state} < r_num_states)
                     && ({1'b0, r_tape_rd} < r_num_colors)
                     && (int'(r_ant_state) < MAX_STATES)
                     && (int'(r_tape_rd) < MAX_COLORS);

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape[tape_waddr] <= tape_wdata;
        end
        if (i_ctrl.accept) begin
            r_tape_rd <= r_tape[tape_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rule_we) begin
            r_rules[rule_waddr] <= rule_wdata;
        end
        if (i_ctrl.look) begin
            r_rule_rd <= r_rules[rule_raddr];
        end
    end

    // An entry outside the configured counts falls back to keeping the colour,
    // going straight on and keeping the state.
    always_comb begin
        if (r_in_range) begin
            entry = r_rule_rd;
        end else begin
            entry.halt       = 1'b0;
            entry.nstate     = r_ant_state;
            entry.turn       = TURN_FWD;
            entry.wcol       = r_tape_rd;
        end
    end

    assign turned      = turn_heading(r_heading, entry.turn);
    assign width_used  = dim_in_use(r_grid_w, WIDTH_LIMIT);
    assign height_used = dim_in_use(r_grid_h, HEIGHT_LIMIT);

    always_comb begin
        n_ant_x     = r_ant_x;
        n_ant_y     = r_ant_y;
        n_heading   = r_heading;
        n_ant_state = r_ant_state;
        n_halted    = r_halted;
        if (place_now) begin
            n_ant_x     = i_item.place_x;
            n_ant_y     = i_item.place_y;
            n_heading   = i_item.place_heading;
            n_ant_state = i_item.place_state;
            n_halted    = 1'b0;
        end else if (do_step) begin
            n_ant_state = entry.nstate;
            n_heading   = turned;
            if (entry.halt) begin
                n_halted = 1'b1;
            end else if (entry.turn != TURN_HOLD) begin
                case (turned)
                    HEAD_NORTH: n_ant_y = step_down(r_ant_y, height_used);
                    HEAD_EAST:  n_ant_x = step_up(r_ant_x, width_used);
                    HEAD_SOUTH: n_ant_y = step_up(r_ant_y, height_used);
                    default:    n_ant_x = step_down(r_ant_x, width_used);
                endcase
            end
        end
    end

    always_comb begin
        result.ant_x_out          = n_ant_x;
        result.ant_y_out          = n_ant_y;
        result.heading_out        = n_heading;
        result.state_out          = n_ant_state;
        result.cell_color_read    = r_tape_rd;
        result.cell_color_written = do_step ? entry.wcol : r_tape_rd;
        result.halted_out         = n_halted;
        result.executed           = do_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_cmd        <= CMD_STEP;
            r_in_range   <= 1'b0;
            r_ant_x      <= '0;
            r_ant_y      <= '0;
            r_heading    <= HEAD_NORTH;
            r_ant_state  <= '0;
            r_halted     <= 1'b0;
            r_grid_w     <= DIM_W'(256);
            r_grid_h     <= DIM_W'(256);
            r_num_states <= CNT_W'(1);
            r_num_colors <= CNT_W'(2);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_clr_addr <= r_clr_addr + TAPE_AW'(1);
            end
            if (i_ctrl.accept) begin
                r_cmd <= i_item.command;
            end
            if (i_ctrl.look) begin
                r_in_range <= in_range;
            end
            r_ant_x     <= n_ant_x;
            r_ant_y     <= n_ant_y;
            r_heading   <= n_heading;
            r_ant_state <= n_ant_state;
            r_halted    <= n_halted;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GRID_W:     r_grid_w     <= i_cfg_data;
                    CFG_GRID_H:     r_grid_h     <= i_cfg_data;
                    CFG_NUM_STATES: r_num_states <= i_cfg_data[CNT_W-1:0];
                    CFG_NUM_COLORS: r_num_colors <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            r_out_valid <= (i_ctrl.look && r_cmd != CMD_STEP) || i_ctrl.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.look || i_ctrl.exec) begin
            r_out <= result;
        end
    end

    assign o_status.clear_done = &r_clr_addr;
    assign o_status.is_step    = (r_cmd == CMD_STEP);
    assign o_result            = r_out;
    assign o_result_valid      = r_out_valid;

    `TSE_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_out_valid, !r_out_valid)
    `TSE_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, i_ctrl.clear |-> !r_out_valid)
    `TSE_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halted && !place_now, r_halted)
    `TSE_ASSERT_NEXT(a_ant_still, i_clk, i_rst_n, !i_ctrl.accept && !i_ctrl.exec, $stable(r_ant_x) && $stable(r_ant_y))

endmodule
